// ----- rtl/ccld_pkg.sv -----
// Shared cell codes, status codes, item modes, register indexes, result type and cell merge rule for the line drawer.
package ccld_pkg;

  // Cell mark codes held in the canvas.
  localparam logic [2:0] CELL_BLANK     = 3'd0;
  localparam logic [2:0] CELL_DASH      = 3'd1;
  localparam logic [2:0] CELL_BAR       = 3'd2;
  localparam logic [2:0] CELL_SLASH     = 3'd3;
  localparam logic [2:0] CELL_BACKSLASH = 3'd4;
  localparam logic [2:0] CELL_CROSS     = 3'd5;

  // Result status codes.
  localparam logic [1:0] STAT_DRAWN    = 2'd0;
  localparam logic [1:0] STAT_BENT     = 2'd1;
  localparam logic [1:0] STAT_OFF      = 2'd2;
  localparam logic [1:0] STAT_READ     = 2'd3;

  // Item modes.
  localparam logic MODE_DRAW = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Configuration register indexes.
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // One finished result offered by the sequencer.
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic [2:0] cell_code;
  } res_t;

  // Update rule for one cell on a line.
  function automatic logic [2:0] merge_mark(input logic [2:0] cur, input logic [2:0] mark);
    logic [2:0] res;
    if (cur == CELL_BLANK) begin
      res = mark;
    end else if (cur == CELL_CROSS || cur == mark) begin
      res = cur;
    end else begin
      res = CELL_CROSS;
    end
    return res;
  endfunction

endpackage

// ----- rtl/ccld_canvas_mem.sv -----
// Canvas storage: one write port and one read port with registered read data.
module ccld_canvas_mem #(
  parameter int Depth = 4096,
  parameter int AddrW = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [2:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [2:0]       rdata_o
);

  logic [2:0] mem [Depth];
  logic [2:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ccld_line_ctrl.sv -----
// Sequencer: clearing pass, item checks, single-cell reads, and the read-modify-write walk along a line.
module ccld_line_ctrl
  import ccld_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64,
  parameter int RowW     = 6,
  parameter int ColW     = 6,
  parameter int Depth    = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 mode_i,
  input  logic [5:0]           x_start_i,
  input  logic [5:0]           y_start_i,
  input  logic [5:0]           x_end_i,
  input  logic [5:0]           y_end_i,
  input  logic [6:0]           cfg_rows_i,
  input  logic [6:0]           cfg_cols_i,
  output res_t                 res_o,
  input  logic                 res_hold_i,
  output logic                 mem_we_o,
  output logic [RowW+ColW-1:0] mem_waddr_o,
  output logic [2:0]           mem_wdata_o,
  output logic                 mem_re_o,
  output logic [RowW+ColW-1:0] mem_raddr_o,
  input  logic [2:0]           mem_rdata_i
);

  localparam int AddrW = RowW + ColW;
  localparam int RowXW = (RowW > 7) ? RowW : 7;
  localparam int ColXW = (ColW > 6) ? ColW : 6;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [6:0] RowsCap = (MAX_ROWS > 127) ? 7'd127 : 7'(MAX_ROWS);
  localparam logic [6:0] ColsCap = (MAX_COLS > 127) ? 7'd127 : 7'(MAX_COLS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_DRAW  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic             mode_q, mode_d;
  logic [5:0]       cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [5:0]       x_end_q, x_end_d, y_end_q, y_end_d;
  logic             sx_en_q, sx_en_d, sx_dn_q, sx_dn_d;
  logic             sy_en_q, sy_en_d, sy_dn_q, sy_dn_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [2:0]       mark_q, mark_d;
  logic [AddrW-1:0] wr_addr_q, wr_addr_d;
  logic [1:0]       status_q, status_d;
  logic [2:0]       code_q, code_d;

  logic [6:0]       rows_used, cols_used;
  logic [RowXW-1:0] srow_w;
  logic [ColXW-1:0] col_w;
  logic [AddrW-1:0] cur_addr;
  logic             x_neg, y_neg;
  logic [5:0]       adx, ady;
  logic             bent, start_on, end_on;
  logic [2:0]       mark_c;
  logic             sx_en_c, sy_en_c;
  logic [5:0]       nx_chk, ny_chk, nx_run, ny_run;

  // Rows and columns in use are capped by the storage size.
  assign rows_used = (cfg_rows_i > RowsCap) ? RowsCap : cfg_rows_i;
  assign cols_used = (cfg_cols_i > ColsCap) ? ColsCap : cfg_cols_i;

  // Storage address of the current point: height is flipped to a storage row.
  assign srow_w   = RowXW'(rows_used) - RowXW'(1) - RowXW'(cur_x_q);
  assign col_w    = ColXW'(cur_y_q);
  assign cur_addr = {srow_w[RowW-1:0], col_w[ColW-1:0]};

  // Line classification; the start point sits in the current-point registers.
  always_comb begin
    x_neg    = x_end_q < cur_x_q;
    y_neg    = y_end_q < cur_y_q;
    adx      = x_neg ? (cur_x_q - x_end_q) : (x_end_q - cur_x_q);
    ady      = y_neg ? (cur_y_q - y_end_q) : (y_end_q - cur_y_q);
    bent     = (adx != 6'd0) && (ady != 6'd0) && (adx != ady);
    start_on = ({1'b0, cur_x_q} < rows_used) && ({1'b0, cur_y_q} < cols_used);
    end_on   = ({1'b0, x_end_q} < rows_used) && ({1'b0, y_end_q} < cols_used);
    sx_en_c  = adx != 6'd0;
    sy_en_c  = ady != 6'd0;
    if (!sx_en_c) begin
      mark_c = CELL_DASH;
    end else if (!sy_en_c) begin
      mark_c = CELL_BAR;
    end else if (x_neg == y_neg) begin
      mark_c = CELL_SLASH;
    end else begin
      mark_c = CELL_BACKSLASH;
    end
  end

  // Next point along the line, from fresh or from stored step directions.
  always_comb begin
    nx_chk = sx_en_c ? (x_neg ? cur_x_q - 6'd1 : cur_x_q + 6'd1) : cur_x_q;
    ny_chk = sy_en_c ? (y_neg ? cur_y_q - 6'd1 : cur_y_q + 6'd1) : cur_y_q;
    nx_run = sx_en_q ? (sx_dn_q ? cur_x_q - 6'd1 : cur_x_q + 6'd1) : cur_x_q;
    ny_run = sy_en_q ? (sy_dn_q ? cur_y_q - 6'd1 : cur_y_q + 6'd1) : cur_y_q;
  end

  // Sequencer next state and memory requests.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    mode_d      = mode_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    x_end_d     = x_end_q;
    y_end_d     = y_end_q;
    sx_en_d     = sx_en_q;
    sx_dn_d     = sx_dn_q;
    sy_en_d     = sy_en_q;
    sy_dn_d     = sy_dn_q;
    cnt_d       = cnt_q;
    mark_d      = mark_q;
    wr_addr_d   = wr_addr_q;
    status_d    = status_q;
    code_d      = code_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wr_addr_q;
    mem_wdata_o = merge_mark(mem_rdata_i, mark_q);
    mem_re_o    = 1'b0;
    mem_raddr_o = cur_addr;
    case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = CELL_BLANK;
        clr_d       = clr_q + AddrW'(1);
        if (clr_q == LastAddr) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d  = mode_i;
          cur_x_d = x_start_i;
          cur_y_d = y_start_i;
          x_end_d = x_end_i;
          y_end_d = y_end_i;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        code_d = CELL_BLANK;
        if (mode_q == MODE_READ) begin
          if (start_on) begin
            mem_re_o = 1'b1;
            state_d  = S_READ;
          end else begin
            status_d = STAT_OFF;
            state_d  = S_DONE;
          end
        end else if (bent) begin
          status_d = STAT_BENT;
          state_d  = S_DONE;
        end else if (!start_on || !end_on) begin
          status_d = STAT_OFF;
          state_d  = S_DONE;
        end else begin
          // First cell read now; the walk writes it next cycle.
          mem_re_o  = 1'b1;
          wr_addr_d = cur_addr;
          mark_d    = mark_c;
          cnt_d     = adx | ady;
          sx_en_d   = sx_en_c;
          sx_dn_d   = x_neg;
          sy_en_d   = sy_en_c;
          sy_dn_d   = y_neg;
          cur_x_d   = nx_chk;
          cur_y_d   = ny_chk;
          state_d   = S_DRAW;
        end
      end
      S_READ: begin
        code_d   = mem_rdata_i;
        status_d = STAT_READ;
        state_d  = S_DONE;
      end
      S_DRAW: begin
        // Write back the cell read last cycle while reading the next one.
        mem_we_o = 1'b1;
        if (cnt_q == 6'd0) begin
          status_d = STAT_DRAWN;
          state_d  = S_DONE;
        end else begin
          mem_re_o  = 1'b1;
          wr_addr_d = cur_addr;
          cur_x_d   = nx_run;
          cur_y_d   = ny_run;
          cnt_d     = cnt_q - 6'd1;
        end
      end
      S_DONE: begin
        if (!res_hold_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o      = state_q != S_IDLE;
  assign res_o.valid     = state_q == S_DONE;
  assign res_o.status    = status_q;
  assign res_o.cell_code = code_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // Item and walk registers.
  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    cur_x_q   <= cur_x_d;
    cur_y_q   <= cur_y_d;
    x_end_q   <= x_end_d;
    y_end_q   <= y_end_d;
    sx_en_q   <= sx_en_d;
    sx_dn_q   <= sx_dn_d;
    sy_en_q   <= sy_en_d;
    sy_dn_q   <= sy_dn_d;
    cnt_q     <= cnt_d;
    mark_q    <= mark_d;
    wr_addr_q <= wr_addr_d;
    status_q  <= status_d;
    code_q    <= code_d;
  end

endmodule

// ----- rtl/char_canvas_line_drawer.sv -----
// Top level of the character-canvas line drawer: configuration, result register, assertions.
// A draw does one read-modify-write per canvas cell, the next cell read while the current one is
// written back; the block takes one item at a time and stalls its input until it is finished.
// After reset the block clears all MAX_ROWS * 2**ceil(log2(MAX_COLS)) canvas cells (4096 at
// the defaults) and holds in_stall_o high meanwhile; configuration writes are taken at any time.
// A finished result waits in an output register while the next item is accepted.
module char_canvas_line_drawer
  import ccld_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_addr_i,
  input  logic [6:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [5:0] x_start_i,
  input  logic [5:0] y_start_i,
  input  logic [5:0] x_end_i,
  input  logic [5:0] y_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [2:0] cell_code_o
);

  localparam int RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ColW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AddrW = RowW + ColW;
  localparam int Depth = MAX_ROWS * (1 << ColW);

  logic [6:0]       cfg_rows_q, cfg_cols_q;
  logic             out_valid_q;
  logic [1:0]       status_q;
  logic [2:0]       code_q;
  res_t             res;
  logic             res_hold;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [2:0]       mem_wdata, mem_rdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_rows_q <= 7'd64;
      cfg_cols_q <= 7'd64;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == REG_ROWS) begin
        cfg_rows_q <= cfg_wdata_i;
      end
      if (cfg_addr_i == REG_COLS) begin
        cfg_cols_q <= cfg_wdata_i;
      end
    end
  end

  assign res_hold = out_valid_q && out_stall_i;

  ccld_line_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .RowW     (RowW),
    .ColW     (ColW),
    .Depth    (Depth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .x_start_i   (x_start_i),
    .y_start_i   (y_start_i),
    .x_end_i     (x_end_i),
    .y_end_i     (y_end_i),
    .cfg_rows_i  (cfg_rows_q),
    .cfg_cols_i  (cfg_cols_q),
    .res_o       (res),
    .res_hold_i  (res_hold),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ccld_canvas_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: loads a result whenever the slot is free or being emptied.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!res_hold) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!res_hold && res.valid) begin
      status_q <= res.status;
      code_q   <= res.cell_code;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign cell_code_o = code_q;

  // The walk never reads the cell it is writing back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("canvas read and write hit the same cell");

  // Only a read transaction returns a nonblank cell code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_READ |-> cell_code_o == CELL_BLANK)
    else $error("draw result carries a cell code");

  // One item at a time: an accepted transaction blocks the input next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while an item is in progress");

endmodule
